// ===== rtl/core/bpfa_pkg.sv =====
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int MAP_WORDS    = 2048;
  localparam int MAX_RUN      = 1024;
  localparam int PAGE_SHIFT   = 12;
  localparam int WORD_BITS    = 32;
  localparam int WIDX_W       = $clog2(MAP_WORDS);
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int FIDX_W       = WIDX_W + BIT_W;
  localparam int FRAME_W      = FIDX_W + 1;
  localparam int ADDR_W       = 28;
  localparam int LEN_W        = 11;
  localparam int CFG_W        = 17;
  localparam int CFG_IDX_W    = 2;
  localparam logic [FRAME_W-1:0] TOTAL_FRAMES = FRAME_W'(MAP_WORDS * WORD_BITS);

  typedef enum logic [1:0] {
    REQ_LOW  = 2'd0,
    REQ_HIGH = 2'd1,
    REQ_RUN  = 2'd2,
    REQ_FREE = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LIMIT = 2'd0,
    CFG_FIRST_FRAME = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RUN_RD,
    ST_RUN_BIT,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan_rd;
    logic scan_chk;
    logic run_rd;
    logic run_bit;
    logic upd_rd;
    logic upd_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    req_t req;
    logic early;
    logic hit;
    logic scan_last;
    logic run_hit;
    logic run_stop;
    logic run_wrap;
    logic upd_last;
  } sts_t;

  // bits of word w that fall inside frames lo..last (inclusive)
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [WIDX_W-1:0] w,
                                                     input logic [FIDX_W-1:0] lo,
                                                     input logic [FIDX_W-1:0] last);
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] ones;
    ones = '1;
    m    = ones;
    if (w == lo[FIDX_W-1:BIT_W]) m = m & (ones << lo[BIT_W-1:0]);
    if (w == last[FIDX_W-1:BIT_W])
      m = m & (ones >> (BIT_W'(WORD_BITS - 1) - last[BIT_W-1:0]));
    return m;
  endfunction

endpackage

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// From accept to result beat, an immediate failure or empty free goes straight to the result; a
// lowest/highest scan reads then checks each bitmap word; a run search reads each word and
// checks its frames in turn; a run or free reads and writes back each word. Busy drops the
// cycle after the beat. One request at a time; the bitmap RAM has a read and a write port.
// The result strobe lasts one cycle and the receiver cannot stall it. Reset: synchronous;
// the bitmap is then cleared to all-used with busy high; configuration writes are taken meanwhile.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [bpfa_pkg::LEN_W-1:0]     in_run_length,
  input  logic [bpfa_pkg::ADDR_W-1:0]    in_frame_address,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [bpfa_pkg::ADDR_W-1:0]    out_alloc_address,
  input  logic                           cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpfa_pkg::CFG_W-1:0]     cfg_wdata
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  bpfa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_run_length     (in_run_length),
    .in_frame_address  (in_frame_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ok            (out_ok),
    .out_alloc_address (out_alloc_address)
  );

endmodule

// ===== rtl/core/bpfa_ram.sv =====
`timescale 1ns / 1ps

module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bpfa_ctrl.sv =====
`timescale 1ns / 1ps

module bpfa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  bpfa_pkg::sts_t  sts,
  output bpfa_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  bpfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bpfa_pkg::ST_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpfa_pkg::ST_CLR:      if (sts.clr_last) state_nxt = bpfa_pkg::ST_IDLE;
      bpfa_pkg::ST_IDLE:     if (start) state_nxt = bpfa_pkg::ST_DISPATCH;
      bpfa_pkg::ST_DISPATCH: begin
        if (sts.early) state_nxt = bpfa_pkg::ST_DONE;
        else begin
          unique case (sts.req) inside
            bpfa_pkg::REQ_LOW, bpfa_pkg::REQ_HIGH: state_nxt = bpfa_pkg::ST_SCAN_RD;
            bpfa_pkg::REQ_RUN:  state_nxt = bpfa_pkg::ST_RUN_RD;
            default:            state_nxt = bpfa_pkg::ST_UPD_RD;
          endcase
        end
      end
      bpfa_pkg::ST_SCAN_RD:  state_nxt = bpfa_pkg::ST_SCAN_CHK;
      bpfa_pkg::ST_SCAN_CHK: begin
        if (sts.hit || sts.scan_last) state_nxt = bpfa_pkg::ST_DONE;
        else state_nxt = bpfa_pkg::ST_SCAN_RD;
      end
      bpfa_pkg::ST_RUN_RD:   state_nxt = bpfa_pkg::ST_RUN_BIT;
      bpfa_pkg::ST_RUN_BIT: begin
        if (sts.run_hit)       state_nxt = bpfa_pkg::ST_UPD_RD;
        else if (sts.run_stop) state_nxt = bpfa_pkg::ST_DONE;
        else if (sts.run_wrap) state_nxt = bpfa_pkg::ST_RUN_RD;
      end
      bpfa_pkg::ST_UPD_RD:   state_nxt = bpfa_pkg::ST_UPD_WR;
      bpfa_pkg::ST_UPD_WR: begin
        if (sts.upd_last) state_nxt = bpfa_pkg::ST_DONE;
        else state_nxt = bpfa_pkg::ST_UPD_RD;
      end
      bpfa_pkg::ST_DONE:     state_nxt = bpfa_pkg::ST_IDLE;
      default:               state_nxt = bpfa_pkg::ST_CLR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.clr      = (state_r == bpfa_pkg::ST_CLR);
    cmd.load     = (state_r == bpfa_pkg::ST_IDLE) && start;
    cmd.scan_rd  = (state_r == bpfa_pkg::ST_SCAN_RD);
    cmd.scan_chk = (state_r == bpfa_pkg::ST_SCAN_CHK);
    cmd.run_rd   = (state_r == bpfa_pkg::ST_RUN_RD);
    cmd.run_bit  = (state_r == bpfa_pkg::ST_RUN_BIT);
    cmd.upd_rd   = (state_r == bpfa_pkg::ST_UPD_RD);
    cmd.upd_wr   = (state_r == bpfa_pkg::ST_UPD_WR);
    busy         = (state_r != bpfa_pkg::ST_IDLE);
    done         = (state_r == bpfa_pkg::ST_DONE);
  end

endmodule

// ===== rtl/core/bpfa_dp.sv =====
`timescale 1ns / 1ps

module bpfa_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpfa_pkg::cmd_t                     cmd,
  output bpfa_pkg::sts_t                     sts,
  input  logic [1:0]                         in_req_type,
  input  logic [bpfa_pkg::LEN_W-1:0]         in_run_length,
  input  logic [bpfa_pkg::ADDR_W-1:0]        in_frame_address,
  input  logic                               cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpfa_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                               out_ok,
  output logic [bpfa_pkg::ADDR_W-1:0]        out_alloc_address
);

  localparam int WB = bpfa_pkg::WORD_BITS;
  localparam int WW = bpfa_pkg::WIDX_W;
  localparam int FW = bpfa_pkg::FIDX_W;
  localparam int BW = bpfa_pkg::BIT_W;
  localparam int LW = bpfa_pkg::LEN_W;
  localparam int PS = bpfa_pkg::PAGE_SHIFT;

  logic [bpfa_pkg::FRAME_W-1:0] limit_r;
  logic [FW-1:0]                first_r;
  bpfa_pkg::req_t               type_r;
  logic [LW-1:0]                len_r;
  logic                         early_r;
  logic [WW-1:0]                w_r;
  logic [FW-1:0]                f_r;
  logic [LW-1:0]                run_r;
  logic [FW-1:0]                lo_r, last_r;
  logic                         set_r;
  logic                         ok_r;
  logic [bpfa_pkg::ADDR_W-1:0]  addr_r;

  logic [bpfa_pkg::FRAME_W-1:0] end_w;
  logic                         empty;
  logic [FW-1:0]                last_win;
  logic [LW-1:0]                free_len;
  logic [FW+1:0]                free_sum;
  logic [FW-1:0]                in_base;
  bpfa_pkg::req_t               in_req;

  logic [WB-1:0] rd_data, wr_data, mask, masked;
  logic          ram_we, ram_re;
  logic [WW-1:0] rd_addr;
  logic [BW-1:0] lo_idx, hi_idx, sel_idx;
  logic          bit_free;
  logic [LW-1:0] run_inc;
  logic [FW-1:0] run_start;

  assign in_req   = bpfa_pkg::req_t'(in_req_type);
  assign end_w    = (limit_r > bpfa_pkg::TOTAL_FRAMES) ? bpfa_pkg::TOTAL_FRAMES : limit_r;
  assign empty    = ({1'b0, first_r} >= end_w);
  assign last_win = FW'(end_w - 1'b1);
  assign free_len = (in_run_length > LW'(bpfa_pkg::MAX_RUN)) ? LW'(bpfa_pkg::MAX_RUN)
                                                             : in_run_length;
  assign in_base  = in_frame_address[PS+FW-1:PS];
  assign free_sum = (FW+2)'(in_base) + (FW+2)'(free_len) - (FW+2)'(1);

  assign mask   = bpfa_pkg::word_mask(w_r, lo_r, last_r);
  assign masked = rd_data & mask;

  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    for (int i = WB - 1; i >= 0; i--) if (masked[i]) lo_idx = BW'(i);
    for (int i = 0; i < WB; i++) if (masked[i]) hi_idx = BW'(i);
  end
  assign sel_idx = (type_r == bpfa_pkg::REQ_HIGH) ? hi_idx : lo_idx;

  assign bit_free  = rd_data[f_r[BW-1:0]];
  assign run_inc   = run_r + 1'b1;
  assign run_start = f_r + FW'(1) - FW'(len_r);

  always_comb begin
    sts           = '0;
    sts.clr_last  = (w_r == {WW{1'b1}});
    sts.req       = type_r;
    sts.early     = early_r;
    sts.hit       = (masked != '0);
    sts.scan_last = (type_r == bpfa_pkg::REQ_HIGH) ? (w_r == lo_r[FW-1:BW])
                                                   : (w_r == last_r[FW-1:BW]);
    sts.run_hit   = bit_free && (run_inc == len_r);
    sts.run_stop  = ({1'b0, f_r} + 1'b1 == end_w);
    sts.run_wrap  = (f_r[BW-1:0] == {BW{1'b1}});
    sts.upd_last  = (w_r == last_r[FW-1:BW]);
  end

  assign ram_re  = cmd.scan_rd || cmd.run_rd || cmd.upd_rd;
  assign rd_addr = cmd.run_rd ? f_r[FW-1:BW] : w_r;
  assign ram_we  = cmd.clr || cmd.upd_wr || (cmd.scan_chk && sts.hit);

  always_comb begin
    if (cmd.clr)         wr_data = '0;
    else if (cmd.upd_wr) wr_data = set_r ? (rd_data | mask) : (rd_data & ~mask);
    else                 wr_data = rd_data & ~(WB'(1) << sel_idx);
  end

  bpfa_ram #(.WIDTH(WB), .DEPTH(bpfa_pkg::MAP_WORDS)) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (w_r),
    .wr_data (wr_data),
    .rd_en   (ram_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bpfa_pkg::TOTAL_FRAMES;
      first_r <= '0;
      w_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bpfa_pkg::CFG_FRAME_LIMIT: limit_r <= cfg_wdata;
          bpfa_pkg::CFG_FIRST_FRAME: first_r <= cfg_wdata[FW-1:0];
          default: ;
        endcase
      end
      if (cmd.clr || cmd.upd_wr) w_r <= w_r + 1'b1;
      else if (cmd.scan_chk && !sts.hit) begin
        if (type_r == bpfa_pkg::REQ_HIGH) w_r <= w_r - 1'b1;
        else                              w_r <= w_r + 1'b1;
      end else if (cmd.run_bit && sts.run_hit) w_r <= run_start[FW-1:BW];
      else if (cmd.load) begin
        if (in_req == bpfa_pkg::REQ_HIGH) w_r <= last_win[FW-1:BW];
        else if (in_req == bpfa_pkg::REQ_FREE) w_r <= in_base[FW-1:BW];
        else w_r <= first_r[FW-1:BW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_req;
      len_r  <= in_run_length;
      ok_r   <= (in_req == bpfa_pkg::REQ_FREE);
      addr_r <= '0;
      f_r    <= first_r;
      run_r  <= '0;
      set_r  <= (in_req == bpfa_pkg::REQ_FREE);
      case (in_req)
        bpfa_pkg::REQ_RUN: begin
          early_r <= empty || (in_run_length == '0) ||
                     (in_run_length > LW'(bpfa_pkg::MAX_RUN));
          lo_r    <= first_r;
          last_r  <= last_win;
        end
        bpfa_pkg::REQ_FREE: begin
          early_r <= (free_len == '0);
          lo_r    <= in_base;
          last_r  <= (free_sum > (FW+2)'({FW{1'b1}})) ? {FW{1'b1}} : free_sum[FW-1:0];
        end
        default: begin
          early_r <= empty;
          lo_r    <= first_r;
          last_r  <= last_win;
        end
      endcase
    end else if (cmd.scan_chk && sts.hit) begin
      ok_r   <= 1'b1;
      addr_r <= {w_r, sel_idx, {PS{1'b0}}};
    end else if (cmd.run_bit) begin
      run_r <= bit_free ? run_inc : '0;
      f_r   <= f_r + 1'b1;
      if (sts.run_hit) begin
        lo_r   <= run_start;
        last_r <= f_r;
        ok_r   <= 1'b1;
        addr_r <= {run_start, {PS{1'b0}}};
      end
    end
  end

  assign out_ok            = ok_r;
  assign out_alloc_address = addr_r;

endmodule

// ===== rtl/core/bpfa_checker.sv =====
`timescale 1ns / 1ps

module bpfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_ok,
  input logic [bpfa_pkg::ADDR_W-1:0] out_alloc_address
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("not idle after result");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_alloc_address == '0))
    else $error("failed request with nonzero address");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_ok            (out_ok),
  .out_alloc_address (out_alloc_address)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bpfa_pkg::*;

  localparam int NFRAMES = MAP_WORDS * WORD_BITS;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct {
    bit              ok;
    bit [ADDR_W-1:0] addr;
  } alloc_res_t;

  typedef struct {
    req_t             req;
    bit [LEN_W-1:0]   len;
    bit [ADDR_W-1:0]  addr;
    bit               known;
    bit               ok;
    bit [ADDR_W-1:0]  exp_addr;
  } dir_row_t;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 start = 0;
  logic                 busy;
  logic [1:0]           in_req_type = '0;
  logic [LEN_W-1:0]     in_run_length = '0;
  logic [ADDR_W-1:0]    in_frame_address = '0;
  logic                 out_valid;
  logic                 out_ok;
  logic [ADDR_W-1:0]    out_alloc_address;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bitmap_page_frame_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_run_length(in_run_length),
    .in_frame_address(in_frame_address),
    .out_valid(out_valid), .out_ok(out_ok), .out_alloc_address(out_alloc_address),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow allocator state
  bit              free_bits [NFRAMES];
  bit [16:0]       lim_reg = 17'd65536;
  bit [15:0]       first_reg = '0;
  alloc_res_t      pending_allocs[$];
  int              errors = 0;
  longint          cycles = 0;
  int              idle_pct = 0;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit [ADDR_W-1:0] page_addr(input int f);
    return ADDR_W'(f << PAGE_SHIFT);
  endfunction

  function automatic alloc_res_t serve_request(input req_t req, input int len,
                                               input bit [ADDR_W-1:0] addr);
    alloc_res_t r;
    int wend;
    int run;
    int base;
    r.ok = 0;
    r.addr = '0;
    wend = (lim_reg < NFRAMES) ? int'(lim_reg) : NFRAMES;
    run = 0;
    case (req)
      REQ_LOW: begin
        for (int f = first_reg; f < wend; f++)
          if (free_bits[f]) begin
            free_bits[f] = 0; r.ok = 1; r.addr = page_addr(f); break;
          end
      end
      REQ_HIGH: begin
        for (int f = wend - 1; f >= int'(first_reg); f--)
          if (free_bits[f]) begin
            free_bits[f] = 0; r.ok = 1; r.addr = page_addr(f); break;
          end
      end
      REQ_RUN: begin
        if (len != 0 && len <= MAX_RUN)
          for (int f = first_reg; f < wend; f++) begin
            if (!free_bits[f]) run = 0;
            else if (++run == len) begin
              for (int k = f + 1 - len; k <= f; k++) free_bits[k] = 0;
              r.ok = 1; r.addr = page_addr(f + 1 - len); break;
            end
          end
      end
      default: begin
        base = int'(addr >> PAGE_SHIFT);
        if (len > MAX_RUN) len = MAX_RUN;
        for (int k = 0; k < len; k++)
          if (base + k < NFRAMES) free_bits[base + k] = 1;
        r.ok = 1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_allocs.size() == 0) report("result beat with nothing expected");
      else begin
        e = pending_allocs.pop_front();
        if (out_ok !== e.ok)
          report($sformatf("ok got %b want %b", out_ok, e.ok));
        if (out_alloc_address !== e.addr)
          report($sformatf("address got %h want %h", out_alloc_address, e.addr));
      end
    end
  end

  task automatic issue(input req_t req, input int len, input bit [ADDR_W-1:0] addr,
                       input bit known = 0, input bit ok = 0,
                       input bit [ADDR_W-1:0] exp_addr = '0);
    alloc_res_t r;
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(12, 1);
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1;
    in_req_type <= req;
    in_run_length <= LEN_W'(len);
    in_frame_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = serve_request(req, len, addr);
    if (known && (r.ok != ok || r.addr != exp_addr))
      report($sformatf("directed row %s: model disagrees with table", req.name()));
    if (known) begin
      r.ok = ok;
      r.addr = exp_addr;
    end
    pending_allocs.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (pending_allocs.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input int data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(data);
    if (idx == CFG_FRAME_LIMIT) lim_reg = 17'(data);
    else if (idx == CFG_FIRST_FRAME) first_reg = 16'(data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item(input int lo, input int hi);
    int sel;
    int len;
    int f;
    bit [ADDR_W-1:0] a;
    sel = $urandom_range(99);
    if (hi <= lo) hi = lo + 64;
    f = $urandom_range(hi - 1, lo);
    a = ADDR_W'((f << PAGE_SHIFT) | $urandom_range(4095));
    if ($urandom_range(9) == 0) a = ADDR_W'($urandom);
    case ($urandom_range(19))
      0:       len = 0;
      1:       len = $urandom_range(2047, MAX_RUN);
      2:       len = $urandom_range(MAX_RUN, 200);
      default: len = $urandom_range(24, 1);
    endcase
    if (sel < 35) issue(REQ_FREE, len, a);
    else if (sel < 55) issue(REQ_LOW, $urandom_range(2047), ADDR_W'($urandom));
    else if (sel < 75) issue(REQ_HIGH, $urandom_range(2047), ADDR_W'($urandom));
    else issue(REQ_RUN, len > 64 && $urandom_range(3) != 0 ? len % 40 : len, a);
  endtask

  dir_row_t dir_rows[] = '{
    '{REQ_LOW,  0,    28'h0,       1, 0, 28'h0},
    '{REQ_RUN,  0,    28'h0,       1, 0, 28'h0},
    '{REQ_RUN,  1025, 28'h0,       1, 0, 28'h0},
    '{REQ_RUN,  2047, 28'hFFFFFFF, 1, 0, 28'h0},
    '{REQ_FREE, 2047, 28'hFFFFFFF, 1, 1, 28'h0},
    '{REQ_HIGH, 0,    28'h0,       1, 1, 28'hFFFF000},
    '{REQ_FREE, 0,    28'h0001234, 1, 1, 28'h0},
    '{REQ_FREE, 4,    28'h0000FFF, 1, 1, 28'h0},
    '{REQ_LOW,  2047, 28'hFFFFFFF, 1, 1, 28'h0},
    '{REQ_RUN,  3,    28'h0,       1, 1, 28'h0001000},
    '{REQ_HIGH, 0,    28'h0,       1, 0, 28'h0},
    '{REQ_FREE, 1024, 28'h0040000, 1, 1, 28'h0},
    '{REQ_RUN,  1024, 28'h0,       1, 1, 28'h0040000},
    '{REQ_FREE, 40,   28'h0100000, 0, 0, 28'h0},
    '{REQ_RUN,  40,   28'h0,       0, 0, 28'h0},
    '{REQ_FREE, 8,    28'h0200000, 0, 0, 28'h0},
    '{REQ_HIGH, 0,    28'h0,       0, 0, 28'h0},
    '{REQ_LOW,  0,    28'h0,       0, 0, 28'h0}
  };

  initial begin
    int lo;
    int hi;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    while (busy) @(negedge clk);

    foreach (dir_rows[i])
      issue(dir_rows[i].req, dir_rows[i].len, dir_rows[i].addr, dir_rows[i].known,
            dir_rows[i].ok, dir_rows[i].exp_addr);
    drain();

    // top of table with limit at its extreme, then an empty window
    cfg_write(CFG_FIRST_FRAME, 65535);
    cfg_write(CFG_FRAME_LIMIT, 65536);
    issue(REQ_FREE, 5, 28'hFFFF000);
    issue(REQ_HIGH, 0, 28'h0);
    issue(REQ_LOW, 0, 28'h0);
    drain();
    cfg_write(CFG_FRAME_LIMIT, 0);
    cfg_write(CFG_FIRST_FRAME, 0);
    issue(REQ_FREE, 3, 28'h0);
    issue(REQ_LOW, 0, 28'h0);
    issue(REQ_RUN, 1, 28'h0);
    issue(REQ_HIGH, 0, 28'h0);
    drain();
    cfg_write(cfg_idx_t'(2), 17'h1FFFF);
    cfg_write(cfg_idx_t'(3), 17'h0AAAA);

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin lo = 0;     hi = 300;    end
        1: begin lo = 65200; hi = 131071; end
        2: begin lo = 65535; hi = 65536;  end
        default: begin
          lo = $urandom_range(65000);
          hi = lo + $urandom_range(512, 64);
        end
      endcase
      cfg_write(CFG_FIRST_FRAME, lo);
      cfg_write(CFG_FRAME_LIMIT, hi);
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 7;
        default: idle_pct = $urandom_range(1) ? 77 : 0;
      endcase
      for (int n = 0; n < 75; n++) begin
        random_item(lo, hi > NFRAMES ? NFRAMES : hi);
        if (p == 5 && n == 30) begin
          // let the pipe run dry mid-phase
          @(negedge clk);
          start <= 0;
          while (pending_allocs.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bpfa_dp.sv
rtl/core/bitmap_page_frame_allocator.sv
rtl/core/bpfa_checker.sv
verif/tb_top.sv
